// File: rtl/core/asa_pkg.sv
package asa_pkg;

	localparam int SAMPLE_W = 10;
	localparam int QCH_W    = 3;
	localparam int AVG_W    = 12;
	localparam int NCH_W    = 3;

	localparam logic CMD_SAMPLE  = 1'b0;
	localparam logic CMD_AVERAGE = 1'b1;

	localparam int RING_TICK_STEP = 4;
	localparam int AVG_SCALE      = 4;

	localparam logic [AVG_W-1:0] AVG_MAX = '1;

	typedef struct packed {
		logic                command;
		logic [SAMPLE_W-1:0] sample_value;
		logic [QCH_W-1:0]    query_channel;
	} asa_req_t;

	typedef struct packed {
		logic [AVG_W-1:0] average;
		logic [NCH_W-1:0] next_channel;
		logic             control_tick;
	} asa_rsp_t;

endpackage

// File: rtl/core/asa_req_if.sv
interface asa_req_if;
	import asa_pkg::*;

	logic     valid;
	logic     ready;
	asa_req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/core/asa_rsp_if.sv
interface asa_rsp_if;
	import asa_pkg::*;

	logic     valid;
	logic     ready;
	asa_rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/core/adc_scan_sample_averager_top.sv
// channel  dir  handshake          payload
// req      in   valid/ready        command, sample_value, query_channel
// rsp      out  valid/ready        average, next_channel, control_tick
//
// a sample transfer makes one write into the sample memory
// an average query sums the ring of the queried channel and scales it by 4/DEPTH:
// one shared adder walks the ring, then a shift (DEPTH/4 a power of two) or a reciprocal multiply scales the sum
// after reset the sample memory is cleared, one entry per cycle
// req stalls while the memory is cleared, while a query runs or while an unread result blocks the rsp register
module adc_scan_sample_averager_top #(
	parameter int CHANNELS = 8,
	parameter int DEPTH    = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	asa_req_if.sink    req,
	asa_rsp_if.source  rsp
);
	import asa_pkg::*;

	localparam int ENTRIES     = CHANNELS * DEPTH;
	localparam int ADDR_W      = $clog2(ENTRIES);
	localparam int CH_W        = $clog2(CHANNELS);
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int SUM_W       = $clog2(DEPTH * ((1 << SAMPLE_W) - 1) + 1);
	localparam int ALU_W       = SUM_W + 1;
	localparam int DIVISOR     = DEPTH / AVG_SCALE;
	localparam bit DIV_IS_POW2 = (DIVISOR & (DIVISOR - 1)) == 0;
	localparam int DIV_SHIFT   = $clog2(DIVISOR);
	localparam int RCP_SHIFT   = SUM_W + DIV_SHIFT;
	localparam int RCP_MUL     = ((1 << RCP_SHIFT) + DIVISOR - 1) / DIVISOR;
	localparam int MUL_W       = SUM_W + 2;
	localparam int PROD_W      = SUM_W + MUL_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACC,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   clr_addr_q;
	logic [CH_W-1:0]     scan_ch_q;
	logic [IDX_W-1:0]    ring_idx_q;
	logic [ADDR_W-1:0]   base_q;
	logic                ch_ok_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [ALU_W-1:0]    acc_q;
	logic [SUM_W-1:0]    quo_q;
	asa_rsp_t            rsp_q;
	logic                rsp_valid_q;

	logic                req_fire;
	logic                rsp_free;
	logic                rsp_load;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [SAMPLE_W-1:0] mem_wdata;
	logic [ADDR_W-1:0]   mem_raddr;
	logic [SAMPLE_W-1:0] mem_rdata;
	logic [ADDR_W-1:0]   slot_addr;
	logic [IDX_W-1:0]    rd_idx;
	logic                scan_wrap;
	logic [CH_W-1:0]     scan_next;
	logic [IDX_W-1:0]    ring_next;
	logic                tick;
	logic                q_in_range;
	logic [ADDR_W-1:0]   q_base;
	logic [PROD_W-1:0]   rcp_prod;
	logic [ALU_W-1:0]    alu_a;
	logic [ALU_W-1:0]    alu_b;
	logic [ALU_W-1:0]    alu_y;
	logic [AVG_W-1:0]    avg_sat;

	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && rsp_free;
	assign req_fire  = req.valid && req.ready;
	assign rsp_load  = (req_fire && req.data.command == CMD_SAMPLE) ||
		(state_q == ST_DONE && rsp_free);

	assign slot_addr = ADDR_W'(ADDR_W'(scan_ch_q) * ADDR_W'(DEPTH)) + ADDR_W'(ring_idx_q);
	assign scan_wrap = scan_ch_q == CH_W'(CHANNELS - 1);
	assign scan_next = scan_wrap ? '0 : scan_ch_q + 1'b1;
	assign ring_next = (ring_idx_q == IDX_W'(DEPTH - 1)) ? '0 : ring_idx_q + 1'b1;
	assign tick      = scan_wrap && ((ring_next % RING_TICK_STEP) == 0);

	assign q_in_range = int'(req.data.query_channel) < CHANNELS;
	assign q_base     = q_in_range ?
		ADDR_W'(ADDR_W'(req.data.query_channel) * ADDR_W'(DEPTH)) : '0;

	assign mem_we    = (state_q == ST_CLEAR) || (req_fire && req.data.command == CMD_SAMPLE);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_addr_q : slot_addr;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : req.data.sample_value;
	assign rd_idx    = (int'(cnt_q) < DEPTH) ? cnt_q[IDX_W-1:0] : '0;
	assign mem_raddr = base_q + ADDR_W'(rd_idx);

	assign rcp_prod = {{MUL_W{1'b0}}, quo_q} * {{SUM_W{1'b0}}, MUL_W'(RCP_MUL)};

	assign alu_a = acc_q;
	assign alu_b = ALU_W'(mem_rdata);

	always_comb begin
		if ({{AVG_W{1'b0}}, quo_q} > {{SUM_W{1'b0}}, AVG_MAX}) begin
			avg_sat = AVG_MAX;
		end else begin
			avg_sat = AVG_W'(quo_q);
		end
	end

	asa_store #(
		.ENTRIES(ENTRIES),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(mem_waddr),
		.wr_data(mem_wdata),
		.rd_addr(mem_raddr),
		.rd_data(mem_rdata)
	);

	asa_alu #(
		.W(ALU_W)
	) u_alu (
		.a(alu_a),
		.b(alu_b),
		.y(alu_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			scan_ch_q   <= '0;
			ring_idx_q  <= '0;
			base_q      <= '0;
			ch_ok_q     <= 1'b0;
			acc_q       <= '0;
			quo_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						if (req.data.command == CMD_SAMPLE) begin
							scan_ch_q <= scan_next;
							if (scan_wrap) begin
								ring_idx_q <= ring_next;
							end
							rsp_q.average      <= '0;
							rsp_q.next_channel <= NCH_W'(scan_next);
							rsp_q.control_tick <= tick;
						end else begin
							base_q  <= q_base;
							ch_ok_q <= q_in_range;
							cnt_q   <= '0;
							acc_q   <= '0;
							state_q <= ST_ACC;
						end
					end
				end
				ST_ACC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q != '0) begin
						acc_q <= alu_y;
					end
					if (cnt_q == CNT_W'(DEPTH)) begin
						if (DIV_IS_POW2) begin
							quo_q   <= SUM_W'(alu_y[SUM_W-1:0] >> DIV_SHIFT);
							state_q <= ST_DONE;
						end else begin
							quo_q   <= alu_y[SUM_W-1:0];
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					quo_q   <= SUM_W'(rcp_prod >> RCP_SHIFT);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_free) begin
						rsp_q.average      <= ch_ok_q ? avg_sat : '0;
						rsp_q.next_channel <= NCH_W'(scan_ch_q);
						rsp_q.control_tick <= 1'b0;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;
endmodule

// File: rtl/core/asa_store.sv
module asa_store #(
	parameter int ENTRIES = 128,
	parameter int ADDR_W  = $clog2(ENTRIES)
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [ADDR_W-1:0]            wr_addr,
	input  logic [asa_pkg::SAMPLE_W-1:0] wr_data,
	input  logic [ADDR_W-1:0]            rd_addr,
	output logic [asa_pkg::SAMPLE_W-1:0] rd_data
);
	import asa_pkg::*;

	logic [SAMPLE_W-1:0] mem_q [ENTRIES];
	logic [SAMPLE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule

// File: rtl/core/asa_alu.sv
module asa_alu #(
	parameter int W = 15
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] y
);
	assign y = a + b;
endmodule

// File: verif/adc_scan_sample_averager_top_test.sv
module adc_scan_sample_averager_top_test;
	import asa_pkg::*;

	localparam int CH_COUNT   = 8;
	localparam int RING_DEPTH = 16;
	localparam int STORE_SIZE = CH_COUNT * RING_DEPTH;

	logic clk = 1'b0;
	logic arst_n;

	asa_req_if req_ch();
	asa_rsp_if rsp_ch();

	adc_scan_sample_averager_top #(
		.CHANNELS(CH_COUNT),
		.DEPTH(RING_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [SAMPLE_W-1:0] shadow_store [STORE_SIZE];
	int unsigned shadow_chan;
	int unsigned shadow_ring;

	asa_rsp_t expected_q[$];
	int errors = 0;
	bit idle_on = 1'b1;
	int long_hold = 0;

	function automatic asa_rsp_t scan_step(asa_req_t item);
		asa_rsp_t r;
		int unsigned sum;
		int unsigned quot;
		int unsigned divisor;
		r = '0;
		if (item.command == CMD_SAMPLE) begin
			shadow_store[shadow_chan * RING_DEPTH + shadow_ring] = item.sample_value;
			shadow_chan = (shadow_chan + 1) % CH_COUNT;
			if (shadow_chan == 0) begin
				shadow_ring = (shadow_ring + 1) % RING_DEPTH;
				r.control_tick = (shadow_ring % RING_TICK_STEP) == 0;
			end
		end else if (item.query_channel < CH_COUNT) begin
			sum = 0;
			for (int i = 0; i < RING_DEPTH; i++)
				sum += 32'(shadow_store[item.query_channel * RING_DEPTH + i]);
			divisor = (RING_DEPTH / AVG_SCALE > 0) ? RING_DEPTH / AVG_SCALE : 1;
			quot = sum / divisor;
			r.average = (quot > AVG_MAX) ? AVG_MAX : quot[AVG_W-1:0];
		end
		r.next_channel = shadow_chan[NCH_W-1:0];
		return r;
	endfunction

	// compare the oldest prediction first, then predict for the new transfer
	always @(posedge clk) begin
		asa_rsp_t exp_rsp;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result avg=%0d ch=%0d tick=%0d", $time,
						rsp_ch.data.average, rsp_ch.data.next_channel,
						rsp_ch.data.control_tick);
					errors++;
				end else begin
					exp_rsp = expected_q.pop_front();
					if (rsp_ch.data.average !== exp_rsp.average) begin
						$display("%0t: average expected %0d actual %0d", $time,
							exp_rsp.average, rsp_ch.data.average);
						errors++;
					end
					if (rsp_ch.data.next_channel !== exp_rsp.next_channel) begin
						$display("%0t: next_channel expected %0d actual %0d", $time,
							exp_rsp.next_channel, rsp_ch.data.next_channel);
						errors++;
					end
					if (rsp_ch.data.control_tick !== exp_rsp.control_tick) begin
						$display("%0t: control_tick expected %0d actual %0d", $time,
							exp_rsp.control_tick, rsp_ch.data.control_tick);
						errors++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready)
				expected_q.push_back(scan_step(req_ch.data));
		end
	end

	// result side ready, with per-transfer stalls and an occasional long hold
	initial begin
		int wait_cycles;
		rsp_ch.ready = 1'b0;
		forever begin
			if (long_hold > 0) begin
				wait_cycles = long_hold;
				long_hold = 0;
			end else begin
				wait_cycles = idle_on ? $urandom_range(0, 5) : 0;
			end
			@(negedge clk);
			if (wait_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!(rsp_ch.valid && arst_n)) @(posedge clk);
		end
	end

	function automatic asa_req_t sample_req(logic [SAMPLE_W-1:0] value);
		asa_req_t item;
		item.command = CMD_SAMPLE;
		item.sample_value = value;
		item.query_channel = QCH_W'($urandom_range(0, 7));
		return item;
	endfunction

	function automatic asa_req_t query_req(logic [QCH_W-1:0] chan);
		asa_req_t item;
		item.command = CMD_AVERAGE;
		item.sample_value = SAMPLE_W'($urandom_range(0, 1023));
		item.query_channel = chan;
		return item;
	endfunction

	function automatic asa_req_t random_req();
		logic [SAMPLE_W-1:0] value;
		case ($urandom_range(0, 7))
			0: value = '0;
			1: value = '1;
			default: value = SAMPLE_W'($urandom_range(0, 1023));
		endcase
		if ($urandom_range(0, 3) == 0)
			return query_req(QCH_W'($urandom_range(0, 7)));
		return sample_req(value);
	endfunction

	task automatic send_req(asa_req_t item);
		int gap;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= item;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic drain_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		logic [SAMPLE_W-1:0] patterns [4];
		patterns = '{10'h000, 10'h3ff, 10'h155, 10'h2aa};
		// store is cleared by reset
		send_req(query_req(QCH_W'(0)));
		send_req(query_req(QCH_W'(7)));
		for (int i = 0; i < 16; i++)
			send_req(sample_req(patterns[i % 4]));
		for (int c = 0; c < 6; c++)
			send_req(query_req(QCH_W'(c)));
		drain_results();
	endtask

	task automatic test_full_scale();
		for (int i = 0; i < STORE_SIZE; i++)
			send_req(sample_req(10'h3ff));
		for (int c = 0; c < CH_COUNT; c++)
			send_req(query_req(QCH_W'(c)));
		drain_results();
	endtask

	task automatic test_backpressure();
		long_hold = 400;
		for (int i = 0; i < 40; i++)
			send_req(random_req());
		drain_results();
	endtask

	task automatic test_random(int count, bit with_idle);
		idle_on = with_idle;
		for (int i = 0; i < count; i++)
			send_req(random_req());
		drain_results();
		idle_on = 1'b1;
	endtask

	initial begin
		for (int i = 0; i < STORE_SIZE; i++)
			shadow_store[i] = '0;
		shadow_chan = 0;
		shadow_ring = 0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_full_scale();
		test_random(700, 1'b1);
		test_backpressure();
		test_random(200, 1'b0);
		test_random(750, 1'b1);

		repeat (2 * RING_DEPTH + 20) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
